/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/prfc_pkg.sv */
// ----------------------------------------------------------------------------
// prfc_pkg
// Types and constants shared by the packet rate feedback controller.
// ----------------------------------------------------------------------------
package prfc_pkg;

   typedef enum logic [1:0] {
      MODE_ADDITIVE     = 2'd0,
      MODE_HALVING      = 2'd1,
      MODE_PROPORTIONAL = 2'd2,
      MODE_DRAIN        = 2'd3
   } mode_type;

   localparam logic [31:0] INIT_SPACING_RESET = 32'd1310720;

   // register select, taken from paddr[2]
   localparam logic REG_MODE    = 1'b0;
   localparam logic REG_SPACING = 1'b1;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_sel_rate;
      logic rate_load;
      logic rate_update;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

/* rtl/prfc_div.sv */
// ----------------------------------------------------------------------------
// prfc_div
// Bit-serial restoring divider of the constant 1000.0 (two fraction scalings)
// by a 32-bit divisor; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prfc_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   divisor,
   output logic                          done,
   output logic [2*FRAC_BITS+10-1:0]     quotient
);
   localparam int DIV_W = 2 * FRAC_BITS + 10;
   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [DIV_W-1:0] DIVIDEND = {10'd1000, {(2 * FRAC_BITS){1'b0}}};

   logic [31:0]      rem_ff;
   logic [31:0]      rem_in;
   logic [DIV_W-1:0] quot_ff;
   logic [DIV_W-1:0] quot_in;
   logic [31:0]      dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [32:0]      rem_shift;
   logic [31:0]      rem_diff;
   logic             fits;

   assign rem_shift = {rem_ff, quot_ff[DIV_W-1]};
   assign rem_diff  = rem_shift[31:0] - dvs_ff;
   assign fits      = (rem_shift >= {1'b0, dvs_ff});
   assign rem_in    = fits ? rem_diff : rem_shift[31:0];
   assign quot_in   = {quot_ff[DIV_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= DIVIDEND;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

/* rtl/prfc_dp.sv */
// ----------------------------------------------------------------------------
// prfc_dp
// Datapath: spacing state, word capture, rate correction laws, saturation
// and the shared reciprocal divider.
// ----------------------------------------------------------------------------
module prfc_dp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  prfc_pkg::cmd_type    cmd,
   output prfc_pkg::status_type status,
   input  prfc_pkg::mode_type   mode,
   input  logic                 spc_load,
   input  logic [31:0]          spc_value,
   input  logic [19:0]          queue_level,
   input  logic [19:0]          queue_target,
   input  logic [31:0]          drain_rate,
   output logic [31:0]          new_spacing,
   output logic [31:0]          new_rate
);
   import prfc_pkg::*;

   localparam int DIV_W   = 2 * FRAC_BITS + 10;
   localparam int QEXT_W  = (DIV_W > 33) ? DIV_W : 33;
   localparam int SUM_W   = FRAC_BITS + 26;
   localparam int PROD_W  = FRAC_BITS + 21;
   localparam int FIFTH_Q = (2 * (1 << FRAC_BITS) + 5) / 10;
   localparam logic signed [SUM_W-1:0] STEP_Q = SUM_W'(3 << FRAC_BITS);
   localparam logic signed [FRAC_BITS-1:0] FIFTH = FRAC_BITS'(FIFTH_Q);
   localparam logic signed [SUM_W-1:0] RATE_MAX_S = {{(SUM_W - 31){1'b0}}, {31{1'b1}}};
   localparam logic signed [SUM_W-1:0] RATE_MIN_S = {{(SUM_W - 31){1'b1}}, {31{1'b0}}};

   logic [31:0]              spacing_ff;
   logic [19:0]              level_ff;
   logic [19:0]              target_ff;
   logic [31:0]              drain_ff;
   logic [31:0]              rate0_ff;
   logic [31:0]              rate0_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [31:0]              rate_ff;
   logic [31:0]              rate_in;
   logic [31:0]              spacing_in;
   logic [31:0]              out_spacing_ff;
   logic [31:0]              out_rate_ff;

   logic                     div_done;
   logic [DIV_W-1:0]         quot;
   logic [QEXT_W-1:0]        quot_ext;
   logic [31:0]              divisor;

   logic signed [20:0]       err;
   logic signed [SUM_W-1:0]  rate0_s;
   logic signed [SUM_W-1:0]  drain_s;
   logic signed [SUM_W-1:0]  diff_s;
   logic signed [SUM_W-1:0]  half_s;
   logic signed [SUM_W-1:0]  sum_s;

   assign divisor = cmd.div_sel_rate ? rate_ff : spacing_ff;

   prfc_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quot)
   );

   assign status.div_done = div_done;
   assign quot_ext        = QEXT_W'(quot);

   assign rate0_in = ((spacing_ff == '0) || (|quot_ext[QEXT_W-1:31])) ?
                     32'h7FFF_FFFF : quot_ext[31:0];

   assign err     = $signed({1'b0, target_ff}) - $signed({1'b0, level_ff});
   assign prod_in = PROD_W'(err) * PROD_W'(FIFTH);
   assign rate0_s = $signed({{(SUM_W - 32){1'b0}}, rate0_ff});
   assign drain_s = $signed({{(SUM_W - 32){1'b0}}, drain_ff});
   assign diff_s  = rate0_s - drain_s;
   assign half_s  = (diff_s + $signed({{(SUM_W - 1){1'b0}}, diff_s[SUM_W-1]})) >>> 1;

   always_comb begin
      case (mode)
         MODE_ADDITIVE: begin
            if (level_ff < target_ff)      sum_s = rate0_s + STEP_Q;
            else if (level_ff > target_ff) sum_s = rate0_s - STEP_Q;
            else                           sum_s = rate0_s;
         end
         MODE_HALVING: begin
            if (level_ff < target_ff)      sum_s = rate0_s + STEP_Q;
            else if (level_ff > target_ff) sum_s = rate0_s >>> 1;
            else                           sum_s = rate0_s;
         end
         MODE_PROPORTIONAL: begin
            sum_s = rate0_s + (SUM_W'(err) <<< (FRAC_BITS - 1));
         end
         default: begin
            sum_s = rate0_s + SUM_W'(prod_ff) - half_s;
         end
      endcase
   end

   always_comb begin
      if (sum_s > RATE_MAX_S)      rate_in = 32'h7FFF_FFFF;
      else if (sum_s < RATE_MIN_S) rate_in = 32'h8000_0000;
      else                         rate_in = sum_s[31:0];
   end

   always_comb begin
      if (rate_ff[31])                                    spacing_in = '0;
      else if ((rate_ff == '0) || (|quot_ext[QEXT_W-1:32])) spacing_in = '1;
      else                                                spacing_in = quot_ext[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= INIT_SPACING_RESET;
      end else if (spc_load) begin
         spacing_ff <= spc_value;
      end else if (cmd.commit) begin
         spacing_ff <= spacing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         level_ff  <= queue_level;
         target_ff <= queue_target;
         drain_ff  <= drain_rate;
      end
      if (cmd.rate_load) begin
         rate0_ff <= rate0_in;
         prod_ff  <= prod_in;
      end
      if (cmd.rate_update) begin
         rate_ff <= rate_in;
      end
      if (cmd.commit) begin
         out_spacing_ff <= spacing_in;
         out_rate_ff    <= rate_ff;
      end
   end

   assign new_spacing = out_spacing_ff;
   assign new_rate    = out_rate_ff;

endmodule

/* rtl/prfc_ctrl.sv */
// ----------------------------------------------------------------------------
// prfc_ctrl
// Controller: sequences capture, the two reciprocal runs, correction and
// the hand-off into the result register.
// ----------------------------------------------------------------------------
module prfc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output prfc_pkg::cmd_type    cmd,
   input  prfc_pkg::status_type status
);
   import prfc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE_DIV,
      ST_RATE_LOAD,
      ST_CORRECT,
      ST_SPC_START,
      ST_SPC_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture   = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_RATE_DIV;
            end
         end
         ST_RATE_DIV: begin
            if (status.div_done) state_in = ST_RATE_LOAD;
         end
         ST_RATE_LOAD: begin
            cmd.rate_load = 1'b1;
            state_in      = ST_CORRECT;
         end
         ST_CORRECT: begin
            cmd.rate_update = 1'b1;
            state_in        = ST_SPC_START;
         end
         ST_SPC_START: begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_rate = 1'b1;
            state_in         = ST_SPC_DIV;
         end
         ST_SPC_DIV: begin
            cmd.div_sel_rate = 1'b1;
            if (status.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/packet_rate_feedback_controller.sv */
// ----------------------------------------------------------------------------
// packet_rate_feedback_controller
// Packet spacing controller driven by receiver queue feedback words.
// ----------------------------------------------------------------------------
// Each feedback word turns the held spacing into a rate (1000/spacing),
// corrects it by the law in control_mode, saturates it and turns it back
// into a new spacing (1000/rate). Both reciprocals run on one bit-serial
// divider at one quotient bit per cycle. One word is in work at a time;
// the result register lets the next word in while a result waits.
// Writing initial_spacing also reloads the spacing.
module packet_rate_feedback_controller #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // queue_level[19:0], queue_target[39:20], drain_rate[71:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // new_spacing[31:0], new_rate[63:32]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import prfc_pkg::*;

   mode_type    mode_ff;
   logic [31:0] init_spacing_ff;
   logic        csr_wr;
   logic        spc_load;
   cmd_type     cmd;
   status_type  status;
   logic [31:0] new_spacing;
   logic [31:0] new_rate;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign spc_load   = csr_wr && (csr_paddr[2] == REG_SPACING);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_ADDITIVE;
         init_spacing_ff <= INIT_SPACING_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_MODE) begin
            mode_ff <= mode_type'(csr_pwdata[1:0]);
         end else begin
            init_spacing_ff <= csr_pwdata;
         end
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MODE:    csr_prdata = {30'd0, mode_ff};
         REG_SPACING: csr_prdata = init_spacing_ff;
         default:     csr_prdata = '0;
      endcase
   end

   prfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   prfc_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .mode         (mode_ff),
      .spc_load     (spc_load),
      .spc_value    (csr_pwdata),
      .queue_level  (req_tdata[19:0]),
      .queue_target (req_tdata[39:20]),
      .drain_rate   (req_tdata[71:40]),
      .new_spacing  (new_spacing),
      .new_rate     (new_rate)
   );

   assign rsp_tdata = {new_rate, new_spacing};

endmodule

/* rtl/prfc_checker.sv */
// ----------------------------------------------------------------------------
// prfc_checker
// Port-level checks on the result stream of the feedback controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   `ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `ASSERT_IMPLY(a_neg_rate_zero_spc, clock, reset, rsp_tvalid && rsp_tdata[63], rsp_tdata[31:0] == 32'h0)
   `ASSERT_IMPLY(a_zero_rate_max_spc, clock, reset, rsp_tvalid && (rsp_tdata[63:32] == 32'h0), rsp_tdata[31:0] == 32'hFFFF_FFFF)
   `ASSERT_NEXT(a_no_early_word, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid))

endmodule

bind packet_rate_feedback_controller prfc_checker u_checker (.*);
